>>> hw/rtl/ppc_pkg.sv
// Shared types and constants of the position PID controller.
// Holds datapath widths, register reset values, register and state codes.
// No dependencies.
`default_nettype none

package ppc_pkg;

  localparam int DATA_W     = 32;               // gains and Q16.16 samples
  localparam int FRAC_W     = 16;               // fraction bits of Q16.16
  localparam int ERR_W      = DATA_W + 1;       // exact difference of two samples
  localparam int ESUM_W     = ERR_W + 1;        // current plus previous error
  localparam int INTEG_W    = 48;               // stored integral, Q32.16
  localparam int MCAND_W    = INTEG_W + 1;      // widest signed multiplicand
  localparam int DIGIT_W    = 4;                // multiplier bits taken per cycle
  localparam int NUM_DIGITS = DATA_W / DIGIT_W;
  localparam int CNT_W      = $clog2(NUM_DIGITS);
  localparam int H_W        = MCAND_W + DIGIT_W; // partial product register
  localparam int SUM_W      = 82;               // exact sum of the three products
  localparam int CFG_IDX_W  = 2;

  localparam logic [DATA_W-1:0] KP_RESET  = 32'd6553600;
  localparam logic [DATA_W-1:0] KI_RESET  = 32'd6553600;
  localparam logic [DATA_W-1:0] KD_RESET  = 32'd917504;
  localparam logic [DATA_W-1:0] HPF_RESET = 32'd1073742;

  localparam logic [SUM_W-1:0]   ROUND_BIAS = SUM_W'(1) << (FRAC_W - 1);
  localparam logic [DATA_W-1:0]  DRIVE_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0]  DRIVE_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [INTEG_W-1:0] INTEG_MAX  = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic [INTEG_W-1:0] INTEG_MIN  = {1'b1, {(INTEG_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_HPF
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_ACCUM,
    ST_OUT
  } state_e;

  // Products in the order they are formed: the integral increment comes first
  typedef enum logic [1:0] {
    TERM_INC,
    TERM_P,
    TERM_D,
    TERM_I
  } term_e;

endpackage

`default_nettype wire

>>> hw/rtl/pid_position_controller.sv
// Position PID controller with trapezoidal integral, Q16.16, one shared
// digit-serial multiplier (4 multiplier bits per cycle). Uses ppc_pkg.
// Each input transaction runs four products through the setup, digit and
// accumulate states, then an output state that waits for a free output.
// With the single digit-serial unit, one item is in flight at a time.
// Reset clears gains to their defaults, integral and previous error to zero.
`default_nettype none

module pid_position_controller (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire  signed [ppc_pkg::DATA_W-1:0]   position_target_i,
  input  wire  signed [ppc_pkg::DATA_W-1:0]   position_measured_i,
  input  wire  signed [ppc_pkg::DATA_W-1:0]   rate_target_i,
  input  wire  signed [ppc_pkg::DATA_W-1:0]   rate_measured_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic signed [ppc_pkg::DATA_W-1:0]   drive_value_o,
  output logic                                saturated_o,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire         [ppc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire         [ppc_pkg::DATA_W-1:0]   cfg_data_i
);

  import ppc_pkg::*;

  state_e state_q, state_d;
  term_e  term_q;

  logic [CNT_W-1:0]  cnt_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] kp_q, ki_q, kd_q, hpf_q;

  logic signed [INTEG_W-1:0] integ_q;
  logic signed [ERR_W-1:0]   prev_q;

  logic signed [ERR_W-1:0]   err_q, rerr_q;
  logic signed [MCAND_W-1:0] mcand_q, mcand_d;
  logic [DATA_W-1:0]         mult_q, mult_d;
  logic signed [H_W-1:0]     h_q;
  logic [DATA_W-1:0]         l_q;
  logic [SUM_W-1:0]          sum_q;
  logic                      sign_q, sat_q;
  logic [DATA_W-1:0]         drive_q;
  logic                      sat_out_q;

  logic                 in_accept, out_free;
  logic [ESUM_W-1:0]    esum, esum_mag;
  logic [DIGIT_W-1:0]   digit;
  logic signed [H_W-1:0] pp, psum;
  logic [INTEG_W:0]     inc_mag, inc_add, integ_wide;
  logic                 inc_cin, integ_ovf;
  logic [INTEG_W-1:0]   integ_d;
  logic [SUM_W-1:0]     product;
  logic [SUM_W-INTEG_W:0] sum_upper;
  logic                 fits;
  logic [DATA_W-1:0]    drive_d;

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign drive_value_o = drive_q;
  assign saturated_o   = sat_out_q;

  assign in_accept = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_q == CNT_W'(NUM_DIGITS - 1)) state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        state_d = (term_q == TERM_I) ? ST_OUT : ST_SETUP;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Error sum and its magnitude; the increment is rounded on the magnitude
  assign esum     = {err_q[ERR_W-1], err_q} + {prev_q[ERR_W-1], prev_q};
  assign esum_mag = esum[ESUM_W-1] ? (ESUM_W'(0) - esum) : esum;

  always_comb begin
    case (term_q)
      TERM_INC: begin
        mcand_d = MCAND_W'(esum_mag);
        mult_d  = hpf_q;
      end
      TERM_P: begin
        mcand_d = MCAND_W'(err_q);
        mult_d  = kp_q;
      end
      TERM_D: begin
        mcand_d = MCAND_W'(rerr_q);
        mult_d  = kd_q;
      end
      TERM_I: begin
        mcand_d = MCAND_W'(integ_q);
        mult_d  = ki_q;
      end
      default: begin
        mcand_d = '0;
        mult_d  = '0;
      end
    endcase
  end

  // One digit of the multiplier against the full multiplicand per cycle
  assign digit = mult_q[DIGIT_W-1:0];
  assign pp    = H_W'($signed({1'b0, digit}) * mcand_q);
  assign psum  = h_q + pp;

  // Increment magnitude = high word plus the rounding carry from the low word
  assign inc_mag    = h_q[INTEG_W:0];
  assign inc_add    = sign_q ? ~inc_mag : inc_mag;
  assign inc_cin    = sign_q ? ~l_q[DATA_W-1] : l_q[DATA_W-1];
  assign integ_wide = {integ_q[INTEG_W-1], integ_q} + inc_add + (INTEG_W + 1)'(inc_cin);
  assign integ_ovf  = integ_wide[INTEG_W] ^ integ_wide[INTEG_W-1];
  assign integ_d    = integ_ovf ? (integ_wide[INTEG_W] ? INTEG_MIN : INTEG_MAX)
                                : integ_wide[INTEG_W-1:0];

  assign product = {h_q[SUM_W-DATA_W-1:0], l_q};

  // Output fits when the rounded sum lies in the signed 48-bit range
  assign sum_upper = sum_q[SUM_W-1:INTEG_W-1];
  assign fits      = (&sum_upper) | ~(|sum_upper);
  assign drive_d   = fits ? sum_q[FRAC_W+DATA_W-1:FRAC_W]
                          : (sum_q[SUM_W-1] ? DRIVE_MIN : DRIVE_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q      <= TERM_INC;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      kp_q        <= KP_RESET;
      ki_q        <= KI_RESET;
      kd_q        <= KD_RESET;
      hpf_q       <= HPF_RESET;
      integ_q     <= '0;
      prev_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_KP:  kp_q  <= cfg_data_i;
          REG_KI:  ki_q  <= cfg_data_i;
          REG_KD:  kd_q  <= cfg_data_i;
          REG_HPF: hpf_q <= cfg_data_i;
          default: ;
        endcase
      end
      // Load a new result, or drop the one just taken
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) term_q <= TERM_INC;
        end
        ST_SETUP: begin
          cnt_q <= '0;
          // Store the current error once the sum with the old one is taken
          if (term_q == TERM_INC) prev_q <= err_q;
        end
        ST_MUL: begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        ST_ACCUM: begin
          if (term_q == TERM_INC) integ_q <= integ_d;
          case (term_q)
            TERM_INC: term_q <= TERM_P;
            TERM_P:   term_q <= TERM_D;
            TERM_D:   term_q <= TERM_I;
            default:  term_q <= TERM_INC;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      err_q  <= ERR_W'(position_target_i) - ERR_W'(position_measured_i);
      rerr_q <= ERR_W'(rate_target_i) - ERR_W'(rate_measured_i);
      sum_q  <= ROUND_BIAS;
      sat_q  <= 1'b0;
    end
    case (state_q)
      ST_SETUP: begin
        mcand_q <= mcand_d;
        mult_q  <= mult_d;
        h_q     <= '0;
        if (term_q == TERM_INC) sign_q <= esum[ESUM_W-1];
      end
      ST_MUL: begin
        h_q    <= psum >>> DIGIT_W;
        l_q    <= {psum[DIGIT_W-1:0], l_q[DATA_W-1:DIGIT_W]};
        mult_q <= mult_q >> DIGIT_W;
      end
      ST_ACCUM: begin
        if (term_q == TERM_INC) begin
          sat_q <= integ_ovf;
        end else begin
          sum_q <= sum_q + product;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          drive_q   <= drive_d;
          sat_out_q <= sat_q | ~fits;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/ppc_checker.sv
// Port-level checks of the position PID controller, attached by bind.
// Depends on ppc_pkg for field widths.
`default_nettype none

module ppc_sva (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 in_valid_i,
  input wire                                 in_ready_o,
  input wire                                 out_valid_o,
  input wire                                 out_ready_i,
  input wire  signed [ppc_pkg::DATA_W-1:0]   drive_value_o,
  input wire                                 saturated_o,
  input wire                                 cfg_valid_i,
  input wire                                 cfg_ready_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_value_o)
                                    && $stable(saturated_o))
    else $error("result changed while stalled");

  // One item in flight: no second transaction right after one
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // A new result only appears as the core finishes, never while idle
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an item in flight");

  // No result directly after a transaction when the output was empty
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o |=> !out_valid_o)
    else $error("result appeared one cycle after input");

  // The configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind pid_position_controller ppc_sva u_ppc_sva (.*);

`default_nettype wire
